FILE: rtl/wbpm_pkg.sv
// ----------------------------------------------------------------------------
// wbpm_pkg
// Shared types and codes for the wildcard byte pattern matcher.
// ----------------------------------------------------------------------------
package wbpm_pkg;

  // Status codes of a result transaction
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_FOUND      = 2'd1,
    ST_NOMATCH    = 2'd2,
    ST_ERROR      = 2'd3
  } status_e;

  // Progress mark codes
  localparam logic [1:0] MK_UNF  = 2'd0;
  localparam logic [1:0] MK_FUL  = 2'd1;
  localparam logic [1:0] MK_UNIQ = 2'd2;

  // Repeat kinds
  localparam logic [2:0] RK_EXACT  = 3'd0;
  localparam logic [2:0] RK_SINGLE = 3'd1;
  localparam logic [2:0] RK_OPT    = 3'd2;
  localparam logic [2:0] RK_ZMORE  = 3'd3;
  localparam logic [2:0] RK_OMORE  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_CRITERIA = 1'b0;
  localparam logic CFG_FOLD     = 1'b1;

  // Saturation point of the criterion pointer
  localparam int unsigned PTR_MAX = 127;

  // One queued transaction from front to back
  typedef struct packed {
    logic        is_load;
    logic        start;
    logic [7:0]  data_byte;
    logic [5:0]  entry;
    logic [1:0]  wsel;
    logic [63:0] word;
    logic [2:0]  kind;
  } q_item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [6:0] criteria_in_use;
    logic       fold_case;
  } cfg_t;

endpackage

FILE: rtl/wbpm_ram.sv
// ----------------------------------------------------------------------------
// wbpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wbpm_front.sv
// ----------------------------------------------------------------------------
// wbpm_front
// Input stage: accepts transactions, drops out-of-range loads, pushes to queue.
// ----------------------------------------------------------------------------
module wbpm_front #(
  parameter int unsigned MAX_CRITERIA = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic              start_new_i,
  input  logic [7:0]        data_byte_i,
  input  logic [5:0]        entry_index_i,
  input  logic [1:0]        word_select_i,
  input  logic [63:0]       set_word_i,
  input  logic [2:0]        repeat_kind_i,
  output logic              push_o,
  output wbpm_pkg::q_item_t item_o,
  input  logic              ready_i
);
  import wbpm_pkg::*;

  localparam int unsigned CW = ($clog2(MAX_CRITERIA + 1) > 8) ? $clog2(MAX_CRITERIA + 1) : 8;
  localparam logic [CW-1:0] MaxC = CW'(MAX_CRITERIA);

  logic    hold_q, hold_d;
  q_item_t item_q;
  logic    accept, keep;

  assign in_stall_o = hold_q && !ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  // Loads beyond capacity vanish here
  assign keep       = !req_type_i || (CW'(entry_index_i) < MaxC);
  assign push_o     = hold_q;
  assign item_o     = item_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = keep;
    end else if (hold_q && ready_i) begin
      hold_d = 1'b0;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.is_load   <= req_type_i;
      item_q.start     <= start_new_i;
      item_q.data_byte <= data_byte_i;
      item_q.entry     <= entry_index_i;
      item_q.wsel      <= word_select_i;
      item_q.word      <= set_word_i;
      item_q.kind      <= repeat_kind_i;
    end
  end

endmodule

FILE: rtl/wbpm_queue.sv
// ----------------------------------------------------------------------------
// wbpm_queue
// Two-entry queue decoupling the front stage from the back end.
// ----------------------------------------------------------------------------
module wbpm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wbpm_pkg::q_item_t item_i,
  output logic              ready_o,
  output logic              valid_o,
  output wbpm_pkg::q_item_t item_o,
  input  logic              pop_i
);
  import wbpm_pkg::*;

  q_item_t    ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= item_i;
    end
  end

endmodule

FILE: rtl/wbpm_back.sv
// ----------------------------------------------------------------------------
// wbpm_back
// Matching sequencer: walks criteria, rolls back, writes loads, holds result.
// ----------------------------------------------------------------------------
module wbpm_back #(
  parameter int unsigned MAX_CRITERIA = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wbpm_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  wbpm_pkg::q_item_t q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o
);
  import wbpm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CRITERIA);
  localparam int unsigned CW = ($clog2(MAX_CRITERIA + 1) > 8) ? $clog2(MAX_CRITERIA + 1) : 8;
  localparam logic [CW-1:0] MaxC = CW'(MAX_CRITERIA);
  localparam logic [CW-1:0] PtrMax = CW'(PTR_MAX);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FRD  = 8'b0000_0010,
    S_FEV  = 8'b0000_0100,
    S_RRD  = 8'b0000_1000,
    S_REV  = 8'b0001_0000,
    S_LRD  = 8'b0010_0000,
    S_LEV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     i_q, i_d, r_q, r_d, ptr_q, ptr_d;
  logic [7:0]        byte_q, byte_d;
  status_e           res_q, res_d;
  logic [MAX_CRITERIA-1:0] vld_q, vld_d;

  logic [CW-1:0]     cnt, rd_idx, ev_idx, midx, p1;
  logic              mwe, err;
  logic [1:0]        mwdata, mark_rd, mark;
  logic [2:0]        kind_rd;
  logic [63:0]       set_rd;
  logic              hit, letter;
  logic              swe;

  // Saturating pointer increment
  function automatic logic [CW-1:0] bump(input logic [CW-1:0] p);
    return (p < PtrMax) ? p + CW'(1) : p;
  endfunction

  // Clamp count of criteria in use
  assign cnt = (CW'(cfg_i.criteria_in_use) > MaxC) ? MaxC : CW'(cfg_i.criteria_in_use);

  // Set membership with optional ASCII case fold; both cases share a quarter
  assign letter = cfg_i.fold_case &&
                  (((byte_q >= 8'h41) && (byte_q <= 8'h5A)) ||
                   ((byte_q >= 8'h61) && (byte_q <= 8'h7A)));
  assign hit = set_rd[byte_q[5:0]] || (letter && set_rd[byte_q[5:0] ^ 6'h20]);

  assign ev_idx = (state_q == S_REV) ? r_q : i_q;
  assign mark   = vld_q[ev_idx[IW-1:0]] ? mark_rd : MK_UNF;

  assign swe = q_pop_o && q_item_i.is_load;

  wbpm_ram #(.WIDTH(64), .DEPTH(MAX_CRITERIA * 4)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i ({IW'(q_item_i.entry), q_item_i.wsel}),
    .wdata_i (q_item_i.word),
    .raddr_i ({rd_idx[IW-1:0], byte_q[7:6]}),
    .rdata_o (set_rd)
  );

  wbpm_ram #(.WIDTH(3), .DEPTH(MAX_CRITERIA)) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (IW'(q_item_i.entry)),
    .wdata_i (q_item_i.kind),
    .raddr_i (rd_idx[IW-1:0]),
    .rdata_o (kind_rd)
  );

  wbpm_ram #(.WIDTH(2), .DEPTH(MAX_CRITERIA)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (midx[IW-1:0]),
    .wdata_i (mwdata),
    .raddr_i (rd_idx[IW-1:0]),
    .rdata_o (mark_rd)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    r_d     = r_q;
    ptr_d   = ptr_q;
    byte_d  = byte_q;
    res_d   = res_q;
    vld_d   = vld_q;
    rd_idx  = i_q;
    midx    = i_q;
    mwe     = 1'b0;
    mwdata  = MK_UNF;
    q_pop_o = 1'b0;
    p1      = ptr_q;
    err     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_item_i.is_load) begin
            byte_d = q_item_i.data_byte;
            if (q_item_i.start) begin
              ptr_d = '0;
              vld_d = '0;
            end
            i_d     = '0;
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        rd_idx = i_q;
        if (i_q > ptr_q) begin
          res_d   = ST_INCOMPLETE;
          state_d = S_OUT;
        end else if (i_q >= cnt) begin
          res_d   = ST_NOMATCH;
          state_d = S_OUT;
        end else begin
          state_d = S_FEV;
        end
      end
      S_FEV: begin
        midx = i_q;
        if (mark == MK_UNIQ) begin
          i_d     = i_q + CW'(1);
          state_d = S_FRD;
        end else if (hit) begin
          if (i_q + CW'(1) == cnt) begin
            res_d   = ST_FOUND;
            state_d = S_OUT;
          end else begin
            unique case (kind_rd)
              RK_EXACT, RK_SINGLE: mwdata = MK_UNIQ;
              RK_OPT: begin
                if (mark == MK_UNF) begin
                  mwdata = MK_FUL;
                  p1     = (i_q == ptr_q) ? bump(ptr_q) : ptr_q;
                end else begin
                  mwdata = MK_UNIQ;
                end
              end
              RK_ZMORE: begin
                mwdata = MK_FUL;
                p1     = (i_q == ptr_q) ? bump(ptr_q) : ptr_q;
              end
              RK_OMORE: begin
                mwdata = MK_FUL;
                p1     = (mark == MK_FUL) ? bump(ptr_q) : ptr_q;
              end
              default: err = 1'b1;
            endcase
            if (err) begin
              res_d   = ST_ERROR;
              state_d = S_OUT;
            end else begin
              mwe = 1'b1;
              if (i_q == p1) begin
                ptr_d   = bump(p1);
                res_d   = ST_INCOMPLETE;
                state_d = S_OUT;
              end else begin
                ptr_d   = p1;
                i_d     = i_q + CW'(1);
                state_d = S_FRD;
              end
            end
          end
        end else begin
          // Miss: either continue, roll back or flag an unknown kind
          i_d     = i_q + CW'(1);
          state_d = S_FRD;
          unique case (kind_rd)
            RK_EXACT, RK_SINGLE: begin
              if (mark == MK_UNF) begin
                r_d     = (ptr_q < cnt) ? ptr_q : cnt;
                state_d = S_RRD;
              end
            end
            RK_OPT: begin
              if ((mark == MK_UNF) && (i_q == ptr_q)) begin
                ptr_d = bump(ptr_q);
              end
              mwe    = 1'b1;
              mwdata = MK_UNIQ;
            end
            RK_ZMORE: begin
              if (i_q == ptr_q) begin
                ptr_d = bump(ptr_q);
              end
              mwe    = 1'b1;
              mwdata = MK_UNIQ;
            end
            RK_OMORE: begin
              if (mark == MK_UNF) begin
                r_d     = (ptr_q < cnt) ? ptr_q : cnt;
                state_d = S_RRD;
              end else begin
                if (i_q == ptr_q) begin
                  ptr_d = bump(ptr_q);
                end
                mwe    = 1'b1;
                mwdata = MK_UNIQ;
              end
            end
            default: begin
              res_d   = ST_ERROR;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_RRD: begin
        rd_idx = r_q - CW'(1);
        if (r_q == '0) begin
          res_d   = ST_NOMATCH;
          state_d = S_OUT;
        end else begin
          r_d     = r_q - CW'(1);
          state_d = S_REV;
        end
      end
      S_REV: begin
        midx = r_q;
        if ((mark == MK_FUL) && (kind_rd == RK_OPT)) begin
          mwe     = 1'b1;
          mwdata  = MK_UNIQ;
          res_d   = ST_INCOMPLETE;
          state_d = S_OUT;
        end else if (mark != MK_UNIQ) begin
          if (hit) begin
            ptr_d = r_q + CW'(1);
            if (r_q + CW'(1) < cnt) begin
              state_d = S_LRD;
            end else begin
              res_d   = ST_INCOMPLETE;
              state_d = S_OUT;
            end
          end else begin
            mwe     = 1'b1;
            mwdata  = MK_UNF;
            state_d = S_RRD;
          end
        end else begin
          state_d = S_RRD;
        end
      end
      S_LRD: begin
        rd_idx  = r_q + CW'(1);
        state_d = S_LEV;
      end
      S_LEV: begin
        midx = r_q + CW'(1);
        if (hit) begin
          ptr_d  = r_q + CW'(2);
          mwe    = 1'b1;
          mwdata = MK_UNIQ;
        end
        res_d   = ST_INCOMPLETE;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (mwe) begin
      vld_d[midx[IW-1:0]] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      vld_q   <= vld_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    r_q    <= r_d;
    byte_q <= byte_d;
    res_q  <= res_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = res_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrMax + CW'(1))
    else $error("criterion pointer out of range");
  a_mark_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mwe |-> (state_q == S_FEV) || (state_q == S_REV) || (state_q == S_LEV))
    else $error("mark write outside an evaluate step");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE) && q_valid_i)
    else $error("queue pop while busy");
  a_feed_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FEV) |-> (i_q < cnt) && (i_q <= ptr_q))
    else $error("feed walk index out of range");
`endif

endmodule

FILE: rtl/wildcard_byte_pattern_matcher.sv
// A load passes through the front stage, the queue and the back end.
// A data byte walks the criteria, each with a RAM read and then an evaluate step,
// followed where needed by rollback steps and a look-ahead.
// One byte is processed at a time by the back-end sequencer; up to three more wait.
// Reset clears the pointer, progress valid bits and control registers at once; no sweep.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher
// Top level: config registers, front stage, queue and matching back end.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher #(
  parameter int unsigned MAX_CRITERIA = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        start_new_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  entry_index_i,
  input  logic [1:0]  word_select_i,
  input  logic [63:0] set_word_i,
  input  logic [2:0]  repeat_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);
  import wbpm_pkg::*;

  cfg_t    cfg_q;
  logic    push, q_ready, q_valid, q_pop;
  q_item_t f_item, q_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CRITERIA: cfg_q.criteria_in_use <= cfg_wdata_i;
        CFG_FOLD:     cfg_q.fold_case       <= cfg_wdata_i[0];
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  wbpm_front #(.MAX_CRITERIA(MAX_CRITERIA)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .start_new_i   (start_new_i),
    .data_byte_i   (data_byte_i),
    .entry_index_i (entry_index_i),
    .word_select_i (word_select_i),
    .set_word_i    (set_word_i),
    .repeat_kind_i (repeat_kind_i),
    .push_o        (push),
    .item_o        (f_item),
    .ready_i       (q_ready)
  );

  wbpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  wbpm_back #(.MAX_CRITERIA(MAX_CRITERIA)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard byte pattern matcher: loads patterns,
// streams well-formed and noisy byte sequences under several configurations
// and compares each status against a behavioral predictor of the matcher.
// ----------------------------------------------------------------------------
module testbench;
  import wbpm_pkg::*;

  localparam int unsigned NCRIT     = 64;
  localparam int unsigned DRAIN_CYC = 4 * NCRIT + 40;
  localparam int unsigned WD_LIMIT  = 20000;

  typedef struct {
    bit        load;
    bit        st;
    bit [7:0]  b;
    bit [5:0]  e;
    bit [1:0]  ws;
    bit [63:0] w;
    bit [2:0]  k;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic        start_new_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic [5:0]  entry_index_i = '0;
  logic [1:0]  word_select_i = '0;
  logic [63:0] set_word_i = '0;
  logic [2:0]  repeat_kind_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  // Predictor state
  bit [63:0]   set_mem [NCRIT*4];
  bit [2:0]    kind_mem [NCRIT];
  bit [1:0]    mark_mem [NCRIT];
  int unsigned crit_ptr;
  int unsigned crit_used;
  bit          fold_en;

  stim_t       pending[$];
  status_e     status_fifo[$];
  int unsigned n_errors;
  int unsigned n_bytes;
  int unsigned n_loads;
  int unsigned n_found;
  int unsigned n_nomatch;
  int unsigned n_err_status;
  bit          in_acc;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_cyc;
  int unsigned idle_cyc;
  bit [7:0]    member [NCRIT];

  wildcard_byte_pattern_matcher #(.MAX_CRITERIA(NCRIT)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------- matcher predictor ----------------
  function automatic bit set_has(int unsigned idx, bit [7:0] b);
    return set_mem[idx*4 + b[7:6]][b[5:0]];
  endfunction

  function automatic bit byte_hits(bit [7:0] b, int unsigned idx);
    if (set_has(idx, b)) return 1'b1;
    if (fold_en && ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
      return set_has(idx, b ^ 8'h20);
    return 1'b0;
  endfunction

  function automatic void ptr_bump();
    if (crit_ptr < PTR_MAX) crit_ptr++;
  endfunction

  function automatic int unsigned live_count();
    return (crit_used > NCRIT) ? NCRIT : crit_used;
  endfunction

  function automatic status_e rewind_match(bit [7:0] b);
    int unsigned cnt;
    int unsigned i;
    int unsigned j;
    cnt = live_count();
    i = (crit_ptr < cnt) ? crit_ptr : cnt;
    while (i > 0) begin
      j = i - 1;
      i--;
      if (mark_mem[j] == MK_FUL && kind_mem[j] == RK_OPT) begin
        mark_mem[j] = MK_UNIQ;
        return ST_INCOMPLETE;
      end
      if (mark_mem[j] != MK_UNIQ) begin
        if (byte_hits(b, j)) begin
          crit_ptr = j + 1;
          if (j + 1 < cnt && byte_hits(b, j + 1)) begin
            crit_ptr = j + 2;
            mark_mem[j+1] = MK_UNIQ;
          end
          return ST_INCOMPLETE;
        end
        mark_mem[j] = MK_UNF;
      end
    end
    return ST_NOMATCH;
  endfunction

  function automatic status_e match_byte(bit [7:0] b);
    int unsigned cnt;
    bit [1:0]    mk;
    bit [2:0]    kd;
    cnt = live_count();
    for (int unsigned i = 0; i <= crit_ptr; i++) begin
      if (i >= cnt) return ST_NOMATCH;
      mk = mark_mem[i];
      if (mk == MK_UNIQ) continue;
      kd = kind_mem[i];
      if (byte_hits(b, i)) begin
        if (i + 1 == cnt) return ST_FOUND;
        case (kd)
          RK_EXACT, RK_SINGLE: mark_mem[i] = MK_UNIQ;
          RK_OPT: begin
            if (mk == MK_UNF) begin
              mark_mem[i] = MK_FUL;
              if (i == crit_ptr) ptr_bump();
            end else begin
              mark_mem[i] = MK_UNIQ;
            end
          end
          RK_ZMORE: begin
            mark_mem[i] = MK_FUL;
            if (i == crit_ptr) ptr_bump();
          end
          RK_OMORE: begin
            if (mk == MK_FUL) ptr_bump();
            mark_mem[i] = MK_FUL;
          end
          default: return ST_ERROR;
        endcase
        if (i == crit_ptr) begin
          ptr_bump();
          return ST_INCOMPLETE;
        end
      end else begin
        case (kd)
          RK_EXACT, RK_SINGLE: begin
            if (mk == MK_UNF) return rewind_match(b);
          end
          RK_OPT: begin
            if (mk == MK_UNF && i == crit_ptr) ptr_bump();
            mark_mem[i] = MK_UNIQ;
          end
          RK_ZMORE: begin
            mark_mem[i] = MK_UNIQ;
            if (i == crit_ptr) ptr_bump();
          end
          RK_OMORE: begin
            if (mk == MK_UNF) return rewind_match(b);
            mark_mem[i] = MK_UNIQ;
            if (i == crit_ptr) ptr_bump();
          end
          default: return ST_ERROR;
        endcase
      end
    end
    return ST_INCOMPLETE;
  endfunction

  // Apply one accepted transaction to the predictor
  function automatic void predict_item(stim_t t);
    status_e s;
    if (t.load) begin
      set_mem[t.e*4 + t.ws] = t.w;
      kind_mem[t.e] = t.k;
      n_loads++;
    end else begin
      if (t.st) begin
        crit_ptr = 0;
        foreach (mark_mem[i]) mark_mem[i] = MK_UNF;
      end
      s = match_byte(t.b);
      status_fifo.push_back(s);
      n_bytes++;
      if (s == ST_FOUND) n_found++;
      if (s == ST_NOMATCH) n_nomatch++;
      if (s == ST_ERROR) n_err_status++;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  // ---------------- driver: bursts with gaps ----------------
  always @(negedge clk_i) begin
    if (in_valid_i && !in_acc) begin
      // hold the stalled transaction
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (pending.size() > 0) begin
      stim_t t;
      t = pending.pop_front();
      req_type_i <= t.load;
      start_new_i <= t.st;
      data_byte_i <= t.b;
      entry_index_i <= t.e;
      word_select_i <= t.ws;
      set_word_i <= t.w;
      repeat_kind_i <= t.k;
      in_valid_i <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // ---------------- receiver stall pattern ----------------
  always @(negedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 512) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      2: out_stall_i <= ((stall_cyc % 23) < 15);
      default: out_stall_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------- monitor, checker and watchdog ----------------
  always @(posedge clk_i) begin
    stim_t t;
    status_e e;
    in_acc = in_valid_i && !in_stall_o;
    if (rst_ni && in_acc) begin
      t.load = req_type_i; t.st = start_new_i; t.b = data_byte_i;
      t.e = entry_index_i; t.ws = word_select_i; t.w = set_word_i;
      t.k = repeat_kind_i;
      predict_item(t);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected status %0d", status_o));
      end else begin
        e = status_fifo.pop_front();
        if (status_o !== e)
          report_mismatch($sformatf("status got %0d exp %0d", status_o, e));
      end
    end
    if (in_acc || (out_valid_o && !out_stall_i)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
      $display("[wildcard_byte_pattern_matcher] ERROR");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic push_load(bit [5:0] e, bit [1:0] ws, bit [63:0] w, bit [2:0] k);
    stim_t t;
    t.load = 1'b1; t.st = 1'($urandom_range(0, 1)); t.b = 8'($urandom);
    t.e = e; t.ws = ws; t.w = w; t.k = k;
    pending.push_back(t);
  endtask

  task automatic push_byte(bit st, bit [7:0] b);
    stim_t t;
    t.load = 1'b0; t.st = st; t.b = b;
    t.e = 6'($urandom); t.ws = 2'($urandom); t.w = {$urandom, $urandom};
    t.k = 3'($urandom);
    pending.push_back(t);
  endtask

  // Wait for the sender and every expected status, then let the block settle
  task automatic drain();
    while (pending.size() > 0 || in_valid_i) @(posedge clk_i);
    while (status_fifo.size() > 0) @(posedge clk_i);
    idle_cyc = 0;
    repeat (DRAIN_CYC) @(posedge clk_i);
    idle_cyc = 0;
  endtask

  task automatic write_cfg(logic idx, bit [6:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CRITERIA) crit_used = 32'(val);
    else fold_en = val[0];
  endtask

  // Load a pattern, then stream sequences that mostly follow it
  task automatic run_phase(int unsigned cnt_cfg, bit fold, int unsigned nseq);
    int unsigned n;
    int unsigned nrl;
    int unsigned len;
    int unsigned k;
    bit [2:0]    kd;
    bit [63:0]   w;
    bit [7:0]    b;
    write_cfg(CFG_CRITERIA, 7'(cnt_cfg));
    write_cfg(CFG_FOLD, 7'(fold));
    n = (cnt_cfg > NCRIT) ? NCRIT : cnt_cfg;
    nrl = (n <= 8) ? n : 8;
    for (int unsigned i = 0; i < n; i++) member[i] = 8'($urandom);
    for (int unsigned i = 0; i < nrl; i++) begin
      k = (n <= 8) ? i : $urandom_range(0, n - 1);
      kd = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      for (int unsigned ws = 0; ws < 4; ws++) begin
        w = (member[k][7:6] == ws) ? (64'd1 << member[k][5:0]) : 64'd0;
        if ($urandom_range(0, 3) == 0) w |= 64'd1 << $urandom_range(0, 63);
        push_load(6'(k), 2'(ws), w, kd);
      end
    end
    for (int unsigned s = 0; s < nseq; s++) begin
      if (s == nseq / 2) drain();
      len = (n == 0) ? 3 : $urandom_range(1, (n > 12 ? 12 : n) + 2);
      k = 0;
      for (int unsigned i = 0; i < len; i++) begin
        if (n == 0 || $urandom_range(0, 6) == 0) begin
          b = 8'($urandom);
        end else begin
          b = member[k % n];
          if (fold && $urandom_range(0, 1) && ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A))
            b ^= 8'h20;
          if ($urandom_range(0, 3) != 0) k++;
        end
        push_byte(i == 0, b);
      end
    end
    drain();
  endtask

  // ---------------- main sequence ----------------
  initial begin
    n_errors = 0; n_bytes = 0; n_loads = 0; n_found = 0; n_nomatch = 0;
    n_err_status = 0; in_acc = 0; burst_left = 1; gap_left = 0;
    stall_cyc = 0; idle_cyc = 0; crit_ptr = 0; crit_used = 0; fold_en = 0;
    foreach (set_mem[i]) set_mem[i] = '0;
    foreach (kind_mem[i]) kind_mem[i] = '0;
    foreach (mark_mem[i]) mark_mem[i] = MK_UNF;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill every criterion so no unwritten entry is ever read
    for (int unsigned e = 0; e < NCRIT; e++)
      for (int unsigned ws = 0; ws < 4; ws++)
        push_load(6'(e), 2'(ws), {$urandom, $urandom} & {$urandom, $urandom},
                  3'($urandom_range(0, 4)));
    drain();

    // directed: empty pattern, full-scale bytes
    write_cfg(CFG_CRITERIA, 7'd0);
    push_byte(1'b1, 8'h00);
    push_byte(1'b0, 8'hFF);
    drain();

    // directed: case folding, repeat kinds and an invalid kind
    push_load(6'd0, 2'd1, 64'd1 << 6'h21, RK_EXACT);      // 'a'
    push_load(6'd0, 2'd0, 64'd0, RK_EXACT);
    push_load(6'd0, 2'd2, 64'd0, RK_EXACT);
    push_load(6'd0, 2'd3, 64'd0, RK_EXACT);
    push_load(6'd1, 2'd0, 64'd0, RK_OMORE);
    push_load(6'd1, 2'd1, 64'd1 << 6'h22, RK_OMORE);      // 'b'
    push_load(6'd1, 2'd2, 64'd0, RK_OMORE);
    push_load(6'd1, 2'd3, 64'd0, RK_OMORE);
    push_load(6'd2, 2'd0, 64'd0, 3'd7);
    push_load(6'd2, 2'd1, 64'd1 << 6'h23, 3'd7);          // 'c', invalid kind
    push_load(6'd2, 2'd2, 64'd0, 3'd7);
    push_load(6'd2, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);
    drain();
    write_cfg(CFG_CRITERIA, 7'd3);
    write_cfg(CFG_FOLD, 7'd1);
    push_byte(1'b1, 8'h41);
    push_byte(1'b0, 8'h62);
    push_byte(1'b0, 8'h42);
    push_byte(1'b0, 8'h7A);
    push_byte(1'b1, 8'h61);
    push_byte(1'b0, 8'h62);
    push_byte(1'b0, 8'h63);
    drain();

    // random phases over several settings, extremes included
    run_phase(1, 0, 11);
    run_phase(3, 1, 16);
    run_phase(5, 0, 16);
    run_phase(8, 1, 14);
    run_phase(64, 0, 7);
    run_phase(127, 1, 6);
    run_phase(2, 1, 16);
    run_phase(6, 0, 16);
    run_phase(4, 1, 16);
    run_phase(0, 0, 5);

    $display("covered %0d loads and %0d data bytes over patterns of 0 to 127 criteria",
             n_loads, n_bytes);
    $display("statuses: %0d found, %0d no match, %0d error", n_found, n_nomatch,
             n_err_status);
    if (n_errors == 0) begin
      $display("[wildcard_byte_pattern_matcher] OK");
    end else begin
      $display("[wildcard_byte_pattern_matcher] ERROR");
    end
    $finish;
  end

endmodule

FILE: wildcard_byte_pattern_matcher.f
rtl/wbpm_pkg.sv
rtl/wbpm_ram.sv
rtl/wbpm_front.sv
rtl/wbpm_queue.sv
rtl/wbpm_back.sv
rtl/wildcard_byte_pattern_matcher.sv
tb/sv/testbench.sv
